// ===== hdl/ray_obb_slab_intersect_defines.svh =====
// assertion macros shared by the checker of the ray/box slab block
// no dependencies; clocked on clk_i, disabled while rst_ni is low
`ifndef RAY_OBB_SLAB_INTERSECT_DEFINES_SVH
`define RAY_OBB_SLAB_INTERSECT_DEFINES_SVH

// same-cycle implication
`define OBB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/obb_pkg.sv =====
// shared constants, types and field helpers of the ray/box slab block
// no dependencies
package obb_pkg;

  localparam int FRAC_BITS_DEF = 10;
  localparam int FW      = 21;          // packed coordinate width
  localparam int REG_W   = 63;          // packed register width
  localparam int EPS_W   = 20;
  localparam int NAX     = 3;
  localparam int REL_W   = FW + 1;      // center minus origin
  localparam int PW      = 44;          // direction projection
  localparam int DW      = 45;          // offset projection
  localparam int DIFF_W  = 46;          // offset plus or minus half width
  localparam int CFG_AW  = 6;
  localparam int CFG_DW  = 64;
  localparam int IN_W    = 128;
  localparam int OUT_W   = 40;

  localparam logic [2:0] REG_CENTER = 3'd0;
  localparam logic [2:0] REG_AXIS_X = 3'd1;
  localparam logic [2:0] REG_AXIS_Y = 3'd2;
  localparam logic [2:0] REG_AXIS_Z = 3'd3;
  localparam logic [2:0] REG_HALF   = 3'd4;
  localparam logic [2:0] REG_EPS    = 3'd5;

  localparam logic [REG_W-1:0] RST_CENTER = '0;
  localparam logic [REG_W-1:0] RST_AXIS_X = REG_W'(64'd1024);
  localparam logic [REG_W-1:0] RST_AXIS_Y = REG_W'(64'd1024 << 21);
  localparam logic [REG_W-1:0] RST_AXIS_Z = REG_W'(64'd1024 << 42);
  localparam logic [REG_W-1:0] RST_HALF   = '0;
  localparam logic [EPS_W-1:0] RST_EPS    = EPS_W'(1);

  localparam logic [2:0] FACE_NONE = 3'd6;

  typedef struct packed {
    logic par;    // slab parallel to the ray
    logic prej;   // parallel and offset outside the slab
    logic s1;     // negative sign of first distance
    logic s2;     // negative sign of second distance
  } obb_side_t;

  function automatic logic signed [FW-1:0] fld(logic [REG_W-1:0] r, int unsigned k);
    return signed'(r[FW*k +: FW]);
  endfunction

endpackage

// ===== hdl/obb_proj.sv =====
// projection stages: offsets, products, dot sums, slab numerators
// depends on obb_pkg
module obb_proj import obb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int NW = DIFF_W + FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [6*FW-1:0]      ray_i,
  input  logic [REG_W-1:0]     center_i,
  input  logic [REG_W-1:0]     axis_i [NAX],
  input  logic [REG_W-1:0]     half_i,
  input  logic [EPS_W-1:0]     eps_i,
  output logic                 vld_o,
  output logic [NW-1:0]        num1_o [NAX],
  output logic [NW-1:0]        num2_o [NAX],
  output logic [PW-1:0]        den_o [NAX],
  output obb_side_t            side_o [NAX]
);

  localparam int HW = FW + FRAC_BITS;

  logic [3:0] vld_q;

  logic signed [REL_W-1:0]  rel_q [NAX];
  logic signed [FW-1:0]     dir_q [NAX];
  logic signed [2*FW-1:0]   pr_q [NAX][NAX];
  logic signed [2*FW:0]     dr_q [NAX][NAX];
  logic signed [PW-1:0]     p_q [NAX];
  logic signed [DW-1:0]     d_q [NAX];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  assign vld_o = vld_q[3];

  // stage 1: offset of centre from origin
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NAX; k++) begin
        rel_q[k] <= REL_W'(fld(center_i, k)) - REL_W'(signed'(ray_i[FW*k +: FW]));
        dir_q[k] <= signed'(ray_i[FW*(k+3) +: FW]);
      end
    end
  end

  // stage 2: products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < NAX; a++) begin
        for (int k = 0; k < NAX; k++) begin
          pr_q[a][k] <= dir_q[k] * fld(axis_i[a], k);
          dr_q[a][k] <= rel_q[k] * fld(axis_i[a], k);
        end
      end
    end
  end

  // stage 3: dot sums
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < NAX; a++) begin
        p_q[a] <= PW'(pr_q[a][0]) + PW'(pr_q[a][1]) + PW'(pr_q[a][2]);
        d_q[a] <= DW'(dr_q[a][0]) + DW'(dr_q[a][1]) + DW'(dr_q[a][2]);
      end
    end
  end

  // stage 4: numerator magnitudes, divisor, parallel test
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < NAX; a++) begin
        logic signed [HW-1:0]     h;
        logic signed [DIFF_W-1:0] dx, hx, df1, df2;
        logic signed [NW-1:0]     n1, n2;
        logic [PW-1:0]            ap;
        logic                     par;
        h   = HW'(fld(half_i, a)) <<< FRAC_BITS;
        dx  = DIFF_W'(d_q[a]);
        hx  = DIFF_W'(h);
        df1 = dx - hx;
        df2 = dx + hx;
        n1  = {df1, {FRAC_BITS{1'b0}}};
        n2  = {df2, {FRAC_BITS{1'b0}}};
        ap  = p_q[a][PW-1] ? PW'(-p_q[a]) : PW'(p_q[a]);
        par = ap <= PW'(eps_i);
        num1_o[a]      <= n1[NW-1] ? NW'(-n1) : NW'(n1);
        num2_o[a]      <= n2[NW-1] ? NW'(-n2) : NW'(n2);
        den_o[a]       <= par ? PW'(1) : ap;
        side_o[a].par  <= par;
        side_o[a].prej <= par && ((dx > hx) || (-dx > hx));
        side_o[a].s1   <= df1[DIFF_W-1] ^ p_q[a][PW-1];
        side_o[a].s2   <= df2[DIFF_W-1] ^ p_q[a][PW-1];
      end
    end
  end

endmodule

// ===== hdl/obb_div.sv =====
// pipelined restoring divider, one quotient bit per stage, six numerators
// over three shared divisors; depends on obb_pkg
module obb_div import obb_pkg::*; #(
  parameter int NW = DIFF_W + FRAC_BITS_DEF,
  parameter int DVW = PW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [NW-1:0]   num1_i [NAX],
  input  logic [NW-1:0]   num2_i [NAX],
  input  logic [DVW-1:0]  den_i [NAX],
  input  obb_side_t       side_i [NAX],
  output logic            vld_o,
  output logic [NW-1:0]   quo1_o [NAX],
  output logic [NW-1:0]   quo2_o [NAX],
  output obb_side_t       side_o [NAX]
);

  logic             vld_q  [NW];
  logic [DVW-1:0]   rem_q  [NW][NAX][2];
  logic [NW-1:0]    wrk_q  [NW][NAX][2];
  logic [DVW-1:0]   den_q  [NW][NAX];
  obb_side_t        side_q [NW][NAX];

  for (genvar s = 0; s < NW; s++) begin : g_st
    logic             vld_in;
    logic [DVW-1:0]   rem_in [NAX][2];
    logic [NW-1:0]    wrk_in [NAX][2];
    logic [DVW-1:0]   den_in [NAX];
    obb_side_t        side_in [NAX];
    logic [DVW-1:0]   rem_d [NAX][2];
    logic [NW-1:0]    wrk_d [NAX][2];

    if (s == 0) begin : g_first
      always_comb begin
        vld_in = vld_i;
        for (int a = 0; a < NAX; a++) begin
          rem_in[a][0] = '0;
          rem_in[a][1] = '0;
          wrk_in[a][0] = num1_i[a];
          wrk_in[a][1] = num2_i[a];
          den_in[a]    = den_i[a];
          side_in[a]   = side_i[a];
        end
      end
    end else begin : g_next
      always_comb begin
        vld_in = vld_q[s-1];
        for (int a = 0; a < NAX; a++) begin
          rem_in[a][0] = rem_q[s-1][a][0];
          rem_in[a][1] = rem_q[s-1][a][1];
          wrk_in[a][0] = wrk_q[s-1][a][0];
          wrk_in[a][1] = wrk_q[s-1][a][1];
          den_in[a]    = den_q[s-1][a];
          side_in[a]   = side_q[s-1][a];
        end
      end
    end

    // shift in the next numerator bit, subtract when it fits
    always_comb begin
      for (int a = 0; a < NAX; a++) begin
        for (int n = 0; n < 2; n++) begin
          logic [DVW:0] trial;
          logic         qb;
          trial = {rem_in[a][n], wrk_in[a][n][NW-1]};
          qb    = trial >= {1'b0, den_in[a]};
          rem_d[a][n] = qb ? DVW'(trial - {1'b0, den_in[a]}) : trial[DVW-1:0];
          wrk_d[a][n] = {wrk_in[a][n][NW-2:0], qb};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        wrk_q[s]  <= wrk_d;
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  always_comb begin
    vld_o = vld_q[NW-1];
    for (int a = 0; a < NAX; a++) begin
      quo1_o[a] = wrk_q[NW-1][a][0];
      quo2_o[a] = wrk_q[NW-1][a][1];
      side_o[a] = side_q[NW-1][a];
    end
  end

endmodule

// ===== hdl/obb_merge.sv =====
// slab ordering, entry/exit merge over axes, saturation and output register
// depends on obb_pkg
module obb_merge import obb_pkg::*; #(
  parameter int NW = DIFF_W + FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [NW-1:0]   quo1_i [NAX],
  input  logic [NW-1:0]   quo2_i [NAX],
  input  obb_side_t       side_i [NAX],
  output logic            vld_o,
  output logic            hit_o,
  output logic [31:0]     t_entry_o,
  output logic [2:0]      face_o
);

  localparam int QW = NW + 1;
  localparam logic signed [QW-1:0] T_MAX = QW'(signed'(32'h7fff_ffff));
  localparam logic signed [QW-1:0] T_MIN = QW'(signed'(32'h8000_0000));

  logic [4:0] vld_q;

  logic signed [QW-1:0] t1_q [NAX], t2_q [NAX];
  logic                 par1_q [NAX], rej1_q;
  logic signed [QW-1:0] en2_q [NAX], ex2_q [NAX];
  logic [2:0]           fc2_q [NAX];
  logic                 par2_q [NAX], rej2_q;
  logic                 have3_q, par3_q, rej3_q;
  logic signed [QW-1:0] tmin3_q, tmax3_q, en3_q, ex3_q;
  logic [2:0]           face3_q, fc3_q;
  logic                 hit4_q, have4_q;
  logic signed [QW-1:0] tmin4_q;
  logic [2:0]           face4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  assign vld_o = vld_q[4];

  // stage 1: signs back on the quotients
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rej1_q <= side_i[0].prej | side_i[1].prej | side_i[2].prej;
      for (int a = 0; a < NAX; a++) begin
        logic signed [QW-1:0] m1, m2;
        m1 = signed'({1'b0, quo1_i[a]});
        m2 = signed'({1'b0, quo2_i[a]});
        t1_q[a]   <= side_i[a].s1 ? -m1 : m1;
        t2_q[a]   <= side_i[a].s2 ? -m2 : m2;
        par1_q[a] <= side_i[a].par;
      end
    end
  end

  // stage 2: order each slab, equal distances take the positive face
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rej2_q <= rej1_q;
      for (int a = 0; a < NAX; a++) begin
        logic neg;
        neg = t1_q[a] < t2_q[a];
        en2_q[a]  <= neg ? t1_q[a] : t2_q[a];
        ex2_q[a]  <= neg ? t2_q[a] : t1_q[a];
        fc2_q[a]  <= 3'(2 * a) + {2'b00, ~neg};
        par2_q[a] <= par1_q[a];
      end
    end
  end

  // stage 3: merge the first two axes; a tie keeps the earlier entry
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      logic                 hv;
      logic signed [QW-1:0] tn, tx;
      logic [2:0]           fc;
      hv = 1'b0;
      tn = '0;
      tx = '0;
      fc = FACE_NONE;
      for (int a = 0; a < 2; a++) begin
        if (!par2_q[a]) begin
          if (!hv || en2_q[a] > tn) begin
            tn = en2_q[a];
            fc = fc2_q[a];
          end
          if (!hv || ex2_q[a] < tx) begin
            tx = ex2_q[a];
          end
          hv = 1'b1;
        end
      end
      have3_q <= hv;
      tmin3_q <= tn;
      tmax3_q <= tx;
      face3_q <= fc;
      en3_q   <= en2_q[2];
      ex3_q   <= ex2_q[2];
      fc3_q   <= fc2_q[2];
      par3_q  <= par2_q[2];
      rej3_q  <= rej2_q;
    end
  end

  // stage 4: third axis; entry past exit rejects (bounds are monotone)
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      logic                 hv;
      logic signed [QW-1:0] tn, tx;
      logic [2:0]           fc;
      hv = have3_q;
      tn = tmin3_q;
      tx = tmax3_q;
      fc = face3_q;
      if (!par3_q) begin
        if (!hv || en3_q > tn) begin
          tn = en3_q;
          fc = fc3_q;
        end
        if (!hv || ex3_q < tx) begin
          tx = ex3_q;
        end
        hv = 1'b1;
      end
      hit4_q  <= !(rej3_q || (hv && (tn > tx)));
      have4_q <= hv;
      tmin4_q <= tn;
      face4_q <= fc;
    end
  end

  // stage 5: saturation into the output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o <= hit4_q;
      if (!hit4_q) begin
        t_entry_o <= '0;
        face_o    <= FACE_NONE;
      end else if (!have4_q) begin
        t_entry_o <= T_MIN[31:0];
        face_o    <= FACE_NONE;
      end else begin
        face_o <= face4_q;
        if (tmin4_q > T_MAX) begin
          t_entry_o <= T_MAX[31:0];
        end else if (tmin4_q < T_MIN) begin
          t_entry_o <= T_MIN[31:0];
        end else begin
          t_entry_o <= tmin4_q[31:0];
        end
      end
    end
  end

endmodule

// ===== hdl/ray_obb_slab_intersect.sv =====
// top level of the ray versus oriented box slab test
// depends on obb_pkg, obb_proj, obb_div, obb_merge
//
// one ray enters per clock and one result leaves per clock while the output
// is not stalled. the pipeline has four projection stages, one stage per
// quotient bit in the restoring dividers (46 + FRAC_BITS bits wide) and
// five stages of slab ordering, merge and saturation ending in the output
// register. the whole pipeline advances whenever the output register is
// empty or being taken, so a stall holds every stage in place. box
// registers sit on the apb port at byte address 8*index and must only be
// written while no ray is in flight. t_entry is the entry distance in
// q21.10 (q(31-FRAC_BITS).FRAC_BITS), saturated; a rejected ray gives hit 0,
// t_entry 0, face 6, and a ray parallel to and inside all three slabs
// gives hit 1, t_entry at its minimum and face 6.
module ray_obb_slab_intersect import obb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // item in: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (21 bits each)
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,
  // item out: hit [0], t_entry [32:1], face [35:33]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int NW = DIFF_W + FRAC_BITS;

  // box registers
  logic [REG_W-1:0] center_q, half_q;
  logic [REG_W-1:0] axis_q [NAX];
  logic [EPS_W-1:0] eps_q;
  logic [2:0]       reg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q  <= RST_CENTER;
      axis_q[0] <= RST_AXIS_X;
      axis_q[1] <= RST_AXIS_Y;
      axis_q[2] <= RST_AXIS_Z;
      half_q    <= RST_HALF;
      eps_q     <= RST_EPS;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CENTER: center_q  <= pwdata[REG_W-1:0];
        REG_AXIS_X: axis_q[0] <= pwdata[REG_W-1:0];
        REG_AXIS_Y: axis_q[1] <= pwdata[REG_W-1:0];
        REG_AXIS_Z: axis_q[2] <= pwdata[REG_W-1:0];
        REG_HALF:   half_q    <= pwdata[REG_W-1:0];
        REG_EPS:    eps_q     <= pwdata[EPS_W-1:0];
        default:    ;   // unmapped addresses ignore the write
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTER: prdata = {1'b0, center_q};
      REG_AXIS_X: prdata = {1'b0, axis_q[0]};
      REG_AXIS_Y: prdata = {1'b0, axis_q[1]};
      REG_AXIS_Z: prdata = {1'b0, axis_q[2]};
      REG_HALF:   prdata = {1'b0, half_q};
      REG_EPS:    prdata = CFG_DW'(eps_q);
      default:    prdata = '0;
    endcase
  end

  // global advance: output register free or being drained
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // projection
  logic            p_vld;
  logic [NW-1:0]   p_num1 [NAX], p_num2 [NAX];
  logic [PW-1:0]   p_den [NAX];
  obb_side_t       p_side [NAX];

  obb_proj #(
    .FRAC_BITS (FRAC_BITS),
    .NW        (NW)
  ) u_proj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .vld_i    (s_axis_tvalid),
    .ray_i    (s_axis_tdata[6*FW-1:0]),
    .center_i (center_q),
    .axis_i   (axis_q),
    .half_i   (half_q),
    .eps_i    (eps_q),
    .vld_o    (p_vld),
    .num1_o   (p_num1),
    .num2_o   (p_num2),
    .den_o    (p_den),
    .side_o   (p_side)
  );

  // slab distances
  logic            d_vld;
  logic [NW-1:0]   d_quo1 [NAX], d_quo2 [NAX];
  obb_side_t       d_side [NAX];

  obb_div #(
    .NW  (NW),
    .DVW (PW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (p_vld),
    .num1_i (p_num1),
    .num2_i (p_num2),
    .den_i  (p_den),
    .side_i (p_side),
    .vld_o  (d_vld),
    .quo1_o (d_quo1),
    .quo2_o (d_quo2),
    .side_o (d_side)
  );

  // merge and output register
  logic        hit;
  logic [31:0] t_entry;
  logic [2:0]  face;

  obb_merge #(
    .NW (NW)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .vld_i     (d_vld),
    .quo1_i    (d_quo1),
    .quo2_i    (d_quo2),
    .side_i    (d_side),
    .vld_o     (m_axis_tvalid),
    .hit_o     (hit),
    .t_entry_o (t_entry),
    .face_o    (face)
  );

  assign m_axis_tdata = {4'b0000, face, t_entry, hit};

endmodule

// ===== hdl/obb_chk.sv =====
// output-side checker of the ray/box slab block, bound to the top level
// depends on ray_obb_slab_intersect_defines.svh and obb_pkg
`include "ray_obb_slab_intersect_defines.svh"

module obb_chk import obb_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  `OBB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled item changed")
  `OBB_ASSERT_NOW(a_miss_clean, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[32:1] == 32'd0 && m_axis_tdata[35:33] == FACE_NONE, "miss with distance or face")
  `OBB_ASSERT_NOW(a_face_range, m_axis_tvalid, m_axis_tdata[35:33] != 3'd7, "face code out of range")
  `OBB_ASSERT_NOW(a_no_entry, m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[35:33] == FACE_NONE, m_axis_tdata[32:1] == 32'h8000_0000, "hit without entry face not at minimum")

endmodule

bind ray_obb_slab_intersect obb_chk u_chk (.*);

// ===== tb/testbench.sv =====
// testbench of ray_obb_slab_intersect: streams rays, predicts hit, entry distance and face
// depends on obb_pkg and the block itself; no files or arguments
`timescale 1ns / 1ps

module testbench;
  import obb_pkg::*;

  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int LATENCY   = FRAC + 55;
  localparam int WDOG_MAX  = 20000;

  typedef struct packed {
    logic             hit;
    logic signed [31:0] t_entry;
    logic [2:0]       face;
  } slab_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  always #1 clk_i = ~clk_i;

  ray_obb_slab_intersect dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // local copy of the box registers
  logic [REG_W-1:0] box_ctr, box_half;
  logic [REG_W-1:0] box_axis [3];
  logic [EPS_W-1:0] box_eps;

  slab_res_t expected_hits [$];
  int  fail_count = 0;
  int  quiet_cycles = 0;
  bit  hold_off = 1'b0;      // long receiver stall asked by a test
  bit  no_gaps = 1'b0;

  function automatic logic signed [63:0] sfld(logic [REG_W-1:0] r, int k);
    logic signed [20:0] f;
    f = r[21*k +: 21];
    return 64'(f);
  endfunction

  // slab method on the full-width fixed-point values
  function automatic slab_res_t predict_slab(logic [IN_W-1:0] ray);
    logic signed [63:0] org [3], dir [3], rel [3];
    logic signed [63:0] p, d, h, ap, t1, t2, tt, tmin, tmax, t;
    logic signed [63:0] scl;
    logic have, neg_side, rej;
    logic [2:0] face;
    slab_res_t r;
    scl = 64'sd1 <<< FRAC;
    have = 1'b0; face = FACE_NONE; tmin = 0; tmax = 0;
    for (int k = 0; k < 3; k++) begin
      org[k] = 64'($signed(ray[21*k +: 21]));
      dir[k] = 64'($signed(ray[21*(k+3) +: 21]));
      rel[k] = sfld(box_ctr, k) - org[k];
    end
    for (int a = 0; a < 3; a++) begin
      p = 0; d = 0; rej = 1'b0;
      for (int k = 0; k < 3; k++) begin
        p += dir[k] * sfld(box_axis[a], k);
        d += rel[k] * sfld(box_axis[a], k);
      end
      h = sfld(box_half, a) * scl;
      ap = (p < 0) ? -p : p;
      if (ap > $signed({44'd0, box_eps})) begin
        t1 = ((d - h) * scl) / p;
        t2 = ((d + h) * scl) / p;
        neg_side = t1 < t2;
        if (!neg_side) begin
          tt = t1; t1 = t2; t2 = tt;
        end
        if (!have || t1 > tmin) begin
          tmin = t1;
          face = 3'(2 * a + (neg_side ? 0 : 1));
        end
        if (!have || t2 < tmax) tmax = t2;
        have = 1'b1;
        if (tmin > tmax) rej = 1'b1;
      end else if (-d > h || d > h) begin
        rej = 1'b1;
      end
      if (rej) begin
        r.hit = 1'b0; r.t_entry = '0; r.face = FACE_NONE;
        return r;
      end
    end
    if (!have) t = -64'sd2147483648;
    else if (tmin > 64'sd2147483647) t = 64'sd2147483647;
    else if (tmin < -64'sd2147483648) t = -64'sd2147483648;
    else t = tmin;
    r.hit = 1'b1; r.t_entry = t[31:0]; r.face = have ? face : FACE_NONE;
    return r;
  endfunction

  function automatic int short_gap();
    if (no_gaps) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // apb write, only while idle
  task automatic write_reg(logic [2:0] idx, logic [CFG_DW-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= CFG_AW'({idx, 3'b000}); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_CENTER: box_ctr = val[REG_W-1:0];
      REG_AXIS_X: box_axis[0] = val[REG_W-1:0];
      REG_AXIS_Y: box_axis[1] = val[REG_W-1:0];
      REG_AXIS_Z: box_axis[2] = val[REG_W-1:0];
      REG_HALF:   box_half = val[REG_W-1:0];
      REG_EPS:    box_eps = val[EPS_W-1:0];
      default: ;
    endcase
  endtask

  // offer one ray and hold it until accepted; valid stays up for the next
  // ray and is dropped by a gap or by drain
  task automatic send_ray(logic [IN_W-1:0] ray);
    int g;
    g = short_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ray;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_hits = {expected_hits, predict_slab(ray)};
  endtask

  function automatic logic [IN_W-1:0] pack_ray(logic [20:0] ox, oy, oz, dx, dy, dz);
    return IN_W'({dz, dy, dx, oz, oy, ox});
  endfunction

  function automatic logic [20:0] rnd_field();
    case ($urandom_range(0, 5))
      0: return 21'h100000;
      1: return 21'h0FFFFF;
      2: return 21'(32'($urandom_range(0, 4096)) - 2048);
      default: return 21'($urandom);
    endcase
  endfunction

  // small coordinates give meaningful hits and misses
  function automatic logic [20:0] near_field(int span);
    return 21'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic logic [62:0] pack3(logic [20:0] a, b, c);
    return {c, b, a};
  endfunction

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic set_unit_box(int hx, hy, hz, int eps);
    write_reg(REG_CENTER, 64'(pack3(21'd0, 21'd0, 21'd0)));
    write_reg(REG_AXIS_X, 64'(pack3(21'd1024, 21'd0, 21'd0)));
    write_reg(REG_AXIS_Y, 64'(pack3(21'd0, 21'd1024, 21'd0)));
    write_reg(REG_AXIS_Z, 64'(pack3(21'd0, 21'd0, 21'd1024)));
    write_reg(REG_HALF, 64'(pack3(21'(hx), 21'(hy), 21'(hz))));
    write_reg(REG_EPS, 64'(eps));
  endtask

  // reset values first: identity axes, zero half widths
  task automatic test_reset_state();
    send_ray(pack_ray('0, '0, '0, '0, '0, '0));
    send_ray(pack_ray(-21'sd1024, '0, '0, 21'd1024, '0, '0));
    drain();
  endtask

  // hits along each axis from both sides, parallel cases, ties, extremes
  task automatic test_directed();
    set_unit_box(1024, 1024, 1024, 1);
    send_ray(pack_ray(-21'sd4096, '0, '0, 21'd1024, '0, '0));
    send_ray(pack_ray(21'd4096, '0, '0, -21'sd1024, '0, '0));
    send_ray(pack_ray('0, -21'sd4096, '0, '0, 21'd1024, '0));
    send_ray(pack_ray('0, 21'd4096, '0, '0, -21'sd1024, '0));
    send_ray(pack_ray('0, '0, -21'sd4096, '0, '0, 21'd1024));
    send_ray(pack_ray('0, '0, 21'd4096, '0, '0, -21'sd1024));
    // all slabs parallel and inside: no entering slab
    send_ray(pack_ray('0, '0, '0, '0, '0, '0));
    // parallel and outside: rejected
    send_ray(pack_ray(21'd4096, '0, '0, '0, 21'd1024, '0));
    // miss by entry beyond exit
    send_ray(pack_ray(-21'sd4096, 21'd4096, '0, 21'd1024, 21'd1024, '0));
    // diagonal giving entry ties between axes
    send_ray(pack_ray(-21'sd4096, -21'sd4096, -21'sd4096, 21'd1024, 21'd1024, 21'd1024));
    // saturation and field extremes
    send_ray(pack_ray(21'h100000, 21'h100000, 21'h100000, 21'd1, 21'd1, 21'd1));
    send_ray(pack_ray(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF, 21'h100000, 21'h100000, 21'h100000));
    send_ray(pack_ray(21'h100000, '0, '0, 21'h0FFFFF, '0, '0));
    send_ray(pack_ray(21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF));
    drain();
    // zero half widths: equal slab distances pick the positive face
    set_unit_box(0, 1024, 1024, 1);
    send_ray(pack_ray(-21'sd2048, '0, '0, 21'd1024, '0, '0));
    send_ray(pack_ray(21'd2048, '0, '0, -21'sd1024, '0, '0));
    drain();
    // negative half width: a parallel slab always rejects
    set_unit_box(-1024, 1024, 1024, 1);
    send_ray(pack_ray('0, '0, '0, '0, 21'd1024, '0));
    send_ray(pack_ray('0, -21'sd4096, '0, 21'd1024, 21'd1024, '0));
    drain();
    // largest epsilon makes small directions parallel
    set_unit_box(1024, 1024, 1024, 20'hFFFFF);
    send_ray(pack_ray('0, '0, '0, 21'd500, 21'd1, 21'd3));
    send_ray(pack_ray(21'd8000, '0, '0, 21'd1024, '0, '0));
    drain();
  endtask

  // random box settings, most rays aimed near the box
  task automatic test_random(int n_sets, int per_set);
    logic [20:0] ax [9];
    logic [IN_W-1:0] ray;
    for (int s = 0; s < n_sets; s++) begin
      if (s % 3 == 0) begin
        write_reg(REG_CENTER, {$urandom, $urandom});
        write_reg(REG_AXIS_X, {$urandom, $urandom});
        write_reg(REG_AXIS_Y, {$urandom, $urandom});
        write_reg(REG_AXIS_Z, {$urandom, $urandom});
        write_reg(REG_HALF, {$urandom, $urandom});
      end else begin
        for (int i = 0; i < 9; i++) ax[i] = near_field(1400);
        write_reg(REG_CENTER, 64'(pack3(near_field(3000), near_field(3000), near_field(3000))));
        write_reg(REG_AXIS_X, 64'(pack3(ax[0], ax[1], ax[2])));
        write_reg(REG_AXIS_Y, 64'(pack3(ax[3], ax[4], ax[5])));
        write_reg(REG_AXIS_Z, 64'(pack3(ax[6], ax[7], ax[8])));
        write_reg(REG_HALF, 64'(pack3(21'($urandom_range(0, 3000)),
                                      21'($urandom_range(0, 3000)),
                                      21'($urandom_range(0, 3000)))));
      end
      case (s % 4)
        0: write_reg(REG_EPS, 64'(0));
        1: write_reg(REG_EPS, 64'(20'hFFFFF));
        default: write_reg(REG_EPS, 64'($urandom_range(0, 5000)));
      endcase
      for (int i = 0; i < per_set; i++) begin
        if ($urandom_range(0, 3) == 0)
          ray = pack_ray(rnd_field(), rnd_field(), rnd_field(),
                         rnd_field(), rnd_field(), rnd_field());
        else
          ray = pack_ray(near_field(8000), near_field(8000), near_field(8000),
                         near_field(2048), near_field(2048), near_field(2048));
        if ($urandom_range(0, 15) == 0) ray[20 +: 1] = $urandom_range(0, 1);
        send_ray(ray);
      end
      drain();
    end
  endtask

  // receiver holds off while rays keep coming, filling the pipeline
  task automatic test_backpressure();
    set_unit_box(2048, 2048, 2048, 1);
    no_gaps = 1'b1;
    hold_off = 1'b1;
    for (int i = 0; i < 150; i++)
      send_ray(pack_ray(near_field(6000), near_field(6000), near_field(6000),
                        near_field(2048), near_field(2048), near_field(2048)));
    no_gaps = 1'b0;
    drain();
  endtask

  // receiver readiness with random gaps, or a long counted stall
  always @(posedge clk_i) begin
    int stall;
    if (hold_off) begin
      m_axis_tready <= 1'b0;
      for (stall = 0; stall < 300; stall++) @(posedge clk_i);
      hold_off = 1'b0;
    end else if (m_axis_tready && $urandom_range(0, 9) < 2) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(0, 19) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(posedge clk_i);
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    slab_res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_hits.size() == 0) begin
        $error("result with nothing expected: %h", m_axis_tdata);
        fail_count++;
      end else begin
        exp_r = expected_hits.pop_front();
        if (m_axis_tdata[0] !== exp_r.hit) begin
          $error("hit: expected %0d, got %0d", exp_r.hit, m_axis_tdata[0]);
          fail_count++;
        end
        if (m_axis_tdata[32:1] !== exp_r.t_entry) begin
          $error("t_entry: expected %0d, got %0d", exp_r.t_entry,
                 $signed(m_axis_tdata[32:1]));
          fail_count++;
        end
        if (m_axis_tdata[35:33] !== exp_r.face) begin
          $error("face: expected %0d, got %0d", exp_r.face, m_axis_tdata[35:33]);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving either way
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else if (rst_ni)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    box_ctr = RST_CENTER;
    box_axis[0] = RST_AXIS_X;
    box_axis[1] = RST_AXIS_Y;
    box_axis[2] = RST_AXIS_Z;
    box_half = RST_HALF;
    box_eps = RST_EPS;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed();
    test_backpressure();
    test_random(30, 58);
    if (fail_count == 0 && expected_hits.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
